>>> rtl/pcfc_pkg.sv
// Shared types and constants for the parallel camera frame capture block.
`default_nettype none
package pcfc_pkg;

    localparam int unsigned WIDTH_W  = 11;
    localparam int unsigned HEIGHT_W = 10;
    localparam int unsigned BPP_W    = 2;
    localparam int unsigned VSYNC_W  = 16;
    localparam int unsigned ROWB_W   = 12;
    localparam int unsigned OFFSET_W = 22;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAYSCALE_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_MIN_HIGH  = 3'd4;

    typedef struct packed {
        logic [WIDTH_W-1:0]  frame_width;
        logic [HEIGHT_W-1:0] frame_height;
        logic [BPP_W-1:0]    bytes_per_pixel;
        logic                grayscale_mode;
        logic [VSYNC_W-1:0]  vsync_min_high;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [7:0]          pixel_byte;
        logic [OFFSET_W-1:0] byte_offset;
        logic                frame_last;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/pcfc_cfg_regs.sv
// Configuration register file for the frame capture block.
`default_nettype none
module pcfc_cfg_regs
    import pcfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:     cfg_next.frame_width     = cfg_data[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT:    cfg_next.frame_height    = cfg_data[HEIGHT_W-1:0];
                CFG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_data[BPP_W-1:0];
                CFG_GRAYSCALE_MODE:  cfg_next.grayscale_mode  = cfg_data[0];
                CFG_VSYNC_MIN_HIGH:  cfg_next.vsync_min_high  = cfg_data[VSYNC_W-1:0];
                default:             cfg_next = cfg_reg;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= 11'd640;
            cfg_reg.frame_height    <= 10'd480;
            cfg_reg.bytes_per_pixel <= 2'd2;
            cfg_reg.grayscale_mode  <= 1'b0;
            cfg_reg.vsync_min_high  <= 16'd100;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/pcfc_capture_fsm.sv
// Sync-tracking state machine, row/byte counters and result formation.
`default_nettype none
module pcfc_capture_fsm
    import pcfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       sample_valid,
    input  wire logic       vsync_level,
    input  wire logic       href_level,
    input  wire logic       pclk_level,
    input  wire logic [7:0] bus_data,
    output result_t         result
);

    typedef enum logic [6:0] {
        PH_WAIT_VS_HIGH   = 7'b000_0001,
        PH_VS_HIGH        = 7'b000_0010,
        PH_WAIT_HREF_HIGH = 7'b000_0100,
        PH_WAIT_PCLK_LOW  = 7'b000_1000,
        PH_WAIT_PCLK_HIGH = 7'b001_0000,
        PH_WAIT_PCLK_FALL = 7'b010_0000,
        PH_WAIT_HREF_LOW  = 7'b100_0000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [VSYNC_W-1:0]  vs_ticks_reg, vs_ticks_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [ROWB_W-1:0]   byte_reg, byte_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    logic [WIDTH_W-1:0]  eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic                bpp_two;
    logic [ROWB_W-1:0]   row_bytes;
    logic [ROWB_W-1:0]   last_kept;
    logic [HEIGHT_W:0]   row_plus1;
    logic [HEIGHT_W-1:0] row_wrapped;
    logic                keep_byte;

    always_comb
    begin
        eff_width  = (cfg.frame_width == '0) ? WIDTH_W'(1) : cfg.frame_width;
        eff_height = (cfg.frame_height == '0) ? HEIGHT_W'(1) : cfg.frame_height;
        bpp_two    = cfg.bytes_per_pixel[1];   // 2 and 3 both mean two bytes
        row_bytes  = bpp_two ? {eff_width, 1'b0} : {1'b0, eff_width};
        last_kept  = row_bytes - ROWB_W'(1);
        if (cfg.grayscale_mode && last_kept[0])
        begin
            last_kept = last_kept - ROWB_W'(1);
        end
        row_plus1   = {1'b0, row_reg} + (HEIGHT_W+1)'(1);
        row_wrapped = row_plus1[HEIGHT_W-1:0];
        keep_byte   = !byte_reg[0] || !cfg.grayscale_mode;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        vs_ticks_next = vs_ticks_reg;
        row_next      = row_reg;
        byte_next     = byte_reg;
        offset_next   = offset_reg;
        result        = '0;
        result.pixel_byte  = bus_data;
        result.byte_offset = offset_reg;
        result.frame_last  = (byte_reg == last_kept) && (row_plus1 >= {1'b0, eff_height});

        if (sample_valid)
        begin
            unique case (phase_reg)
                PH_WAIT_VS_HIGH:
                begin
                    if (vsync_level)
                    begin
                        vs_ticks_next = VSYNC_W'(1);
                        phase_next    = PH_VS_HIGH;
                    end
                end
                PH_VS_HIGH:
                begin
                    if (vsync_level)
                    begin
                        if (vs_ticks_reg != '1)
                        begin
                            vs_ticks_next = vs_ticks_reg + VSYNC_W'(1);
                        end
                    end
                    else if (vs_ticks_reg >= cfg.vsync_min_high)
                    begin
                        row_next    = '0;
                        byte_next   = '0;
                        offset_next = '0;
                        phase_next  = PH_WAIT_HREF_HIGH;
                    end
                    else
                    begin
                        phase_next = PH_WAIT_VS_HIGH;   // glitch, too short
                    end
                end
                PH_WAIT_HREF_HIGH:
                begin
                    if (href_level)
                    begin
                        phase_next = PH_WAIT_PCLK_LOW;
                    end
                end
                PH_WAIT_PCLK_LOW:
                begin
                    if (!pclk_level)
                    begin
                        byte_next  = '0;
                        phase_next = PH_WAIT_PCLK_HIGH;
                    end
                end
                PH_WAIT_PCLK_HIGH:
                begin
                    if (pclk_level)
                    begin
                        if (keep_byte)
                        begin
                            result.valid = 1'b1;
                            offset_next  = offset_reg + OFFSET_W'(1);
                        end
                        byte_next  = byte_reg + ROWB_W'(1);
                        phase_next = PH_WAIT_PCLK_FALL;
                    end
                end
                PH_WAIT_PCLK_FALL:
                begin
                    // href drop also ends the wait
                    if (!pclk_level || !href_level)
                    begin
                        phase_next = (byte_reg >= row_bytes) ? PH_WAIT_HREF_LOW
                                                             : PH_WAIT_PCLK_HIGH;
                    end
                end
                PH_WAIT_HREF_LOW:
                begin
                    if (!href_level)
                    begin
                        if (row_wrapped >= eff_height || row_wrapped == '0)
                        begin
                            row_next      = '0;
                            vs_ticks_next = '0;
                            phase_next    = PH_WAIT_VS_HIGH;
                        end
                        else
                        begin
                            row_next   = row_wrapped;
                            phase_next = PH_WAIT_HREF_HIGH;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT_VS_HIGH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT_VS_HIGH;
            vs_ticks_reg <= '0;
            row_reg      <= '0;
            byte_reg     <= '0;
            offset_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            vs_ticks_reg <= vs_ticks_next;
            row_reg      <= row_next;
            byte_reg     <= byte_next;
            offset_reg   <= offset_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/pcfc_out_skid.sv
// Result register plus one skid entry on the output stream.
`default_nettype none
module pcfc_out_skid
    import pcfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire result_t                result,
    output logic                        in_ready,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int unsigned PAY_W = 8 + OFFSET_W + 1;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [PAY_W-1:0] out_data_reg, out_data_next;
    logic [PAY_W-1:0] skid_data_reg, skid_data_next;
    logic [PAY_W-1:0] new_data;
    logic             pop;

    assign new_data = {result.frame_last, result.byte_offset, result.pixel_byte};
    assign pop      = out_valid_reg && m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // no new request can arrive while the skid entry is full
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = new_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = new_data;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready      = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-PAY_W+1){1'b0}}, out_data_reg[PAY_W-2:0]};
    assign m_axis_tlast  = out_data_reg[PAY_W-1];

endmodule
`default_nettype wire

>>> rtl/parallel_camera_frame_capture.sv
// Top level of the parallel camera frame capture block.
//
//  channel   dir   handshake                        payload
//  s_axis    in    s_axis_tvalid / s_axis_tready    pin sample (vsync, href, pclk, data)
//  m_axis    out   m_axis_tvalid / m_axis_tready    captured byte, offset, tlast = frame end
//  cfg       in    cfg_we (no back-pressure)        register index + write data
//
// One pin sample is taken per cycle while s_axis_tready is high; each request moves
// the capture state machine by at most one phase in the same cycle and yields zero or
// one byte request. Results leave through a result register backed by one skid entry,
// so input keeps flowing while one output request is stalled; s_axis_tready drops
// only when both are full. New byte requests are registered in one of the two.
// rst_n is asynchronous, active low: registers return to their defaults,
// the machine waits for a vsync high pulse and the output side is empty.
`default_nettype none
module parallel_camera_frame_capture
    import pcfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // sample stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [0] vsync_level, [1] href_level, [2] pclk_level, [10:3] bus_data, [15:11] zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // captured byte stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [7:0] pixel_byte, [29:8] byte_offset, [31:30] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast,   // frame_last
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t result;
    logic    in_ready;
    logic    sample_valid;

    // a sample counts only when the handshake completes
    assign s_axis_tready = in_ready;
    assign sample_valid  = s_axis_tvalid && in_ready;

    pcfc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // phase tracking, counters and byte selection
    pcfc_capture_fsm u_capture_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .vsync_level  (s_axis_tdata[0]),
        .href_level   (s_axis_tdata[1]),
        .pclk_level   (s_axis_tdata[2]),
        .bus_data     (s_axis_tdata[10:3]),
        .result       (result)
    );

    // result register with skid entry
    pcfc_out_skid u_out_skid (
        .clk           (clk),
        .rst_n         (rst_n),
        .result        (result),
        .in_ready      (in_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> rtl/pcfc_checker.sv
// Port-level checks for the frame capture block, bound to the top level.
`default_nettype none
module pcfc_checker
    import pcfc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    // a stalled output request holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    // input back-pressure only when the output register is occupied
    a_ready_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output register");

    // draining the output frees the skid entry next cycle
    a_ready_recovers: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("input still stalled after output drained");

    // padding bits above the offset stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:8+OFFSET_W] == '0)
        else $error("nonzero padding in output data");

endmodule

bind parallel_camera_frame_capture pcfc_checker u_pcfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
